// File: rtl/lpct_pkg.sv
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing count table.
// ----------------------------------------------------------------------------
package lpct_pkg;

    // default sizes of the slot store
    localparam int SLOTS_DEF      = 1024;
    localparam int COUNT_BITS_DEF = 16;

    // item field widths
    localparam int OPC_W    = 2;
    localparam int KEY_W    = 31;
    localparam int OCOUNT_W = 16;
    localparam int STATUS_W = 2;

    // configuration
    localparam int                CFG_W          = 11;
    localparam int                PADDR_W        = 3;
    localparam int                PDATA_W        = 32;
    localparam int                REG_TABLE_SIZE = 0;
    localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 11'd1024;

    // key modulo: digit bits retired per cycle and division steps per key
    localparam int DIV_DIGIT_BITS = 4;
    localparam int DIV_STEPS      = 8;
    localparam int DIV_W          = DIV_DIGIT_BITS * DIV_STEPS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // opcodes
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OPC_W-1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_step;
        logic div_step;
        logic probe_init;
        logic rd_en;
        logic probe_adv;
        logic finish;
        logic res_nop;
        logic out_load;
    } lpct_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic op_nop;
        logic div_last;
        logic stop;
        logic last_probe;
        logic out_free;
    } lpct_stat_t;

endpackage

// File: rtl/linear_probe_count_table.sv
// ----------------------------------------------------------------------------
// linear_probe_count_table
// Counting hash table with open addressing and linear probing. Each item is
// an insert (count up), search or delete of a 31-bit key, or a no-op; each
// gives one result item with the key's count (zero after a delete) and a
// status. An item passes from acceptance to a ready result through a load
// step, the key modulo unit at four key bits a cycle, a step to set the
// probe pointer, a registered slot memory read and check for each slot
// probed, and a move of the result into the output register once it is
// free; a no-op skips the modulo and probing. Deletes leave no tombstone.
// After reset a clearing pass writes every slot empty, one a cycle; no item
// is taken until it ends, while table_size writes are taken throughout.
// ----------------------------------------------------------------------------
module linear_probe_count_table #(
    parameter int SLOTS      = lpct_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = lpct_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [30:0] key, [31] zero
    input  logic [lpct_pkg::OPC_W-1:0]    s_tuser,   // [1:0] opcode
    // result out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpct_pkg::OCOUNT_W-1:0] m_tdata,   // [15:0] count
    output logic [lpct_pkg::STATUS_W-1:0] m_tuser,   // [1:0] status
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpct_pkg::PADDR_W-1:0]  paddr,
    input  logic [lpct_pkg::PDATA_W-1:0]  pwdata,
    output logic [lpct_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [lpct_pkg::CFG_W-1:0] table_size_reg;
    logic                       reg_sel;
    lpct_pkg::lpct_cmd_t        cmd;
    lpct_pkg::lpct_stat_t       stat;

    assign reg_sel = (paddr[2] == 1'(lpct_pkg::REG_TABLE_SIZE));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? lpct_pkg::PDATA_W'(table_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= lpct_pkg::TABLE_SIZE_RST;
        else if (psel && penable && pwrite && pready && reg_sel)
            table_size_reg <= pwdata[lpct_pkg::CFG_W-1:0];
    end

    lpct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpct_dpath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .table_size (table_size_reg),
        .opcode     (s_tuser),
        .key        (s_tdata[lpct_pkg::KEY_W-1:0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .count      (m_tdata),
        .status     (m_tuser)
    );

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in flight");

    // the output register is loaded only when free or being drained
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before being taken");

    // a full table or a missing key never reports a count
    a_err_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == lpct_pkg::STAT_FULL
                      || m_tuser == lpct_pkg::STAT_MISSING)) |-> (m_tdata == '0))
        else $error("nonzero count with error status");

endmodule

// File: rtl/lpct_dpath.sv
// ----------------------------------------------------------------------------
// lpct_dpath
// Datapath: item registers, key modulo unit, probe pointer, slot memory,
// result update and output register.
// ----------------------------------------------------------------------------
module lpct_dpath #(
    parameter int SLOTS      = lpct_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = lpct_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpct_pkg::lpct_cmd_t            cmd,
    output lpct_pkg::lpct_stat_t           stat,
    input  logic [lpct_pkg::CFG_W-1:0]     table_size,
    input  logic [lpct_pkg::OPC_W-1:0]     opcode,
    input  logic [lpct_pkg::KEY_W-1:0]     key,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [lpct_pkg::OCOUNT_W-1:0]  count,
    output logic [lpct_pkg::STATUS_W-1:0]  status
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SIZE_W = $clog2(SLOTS + 1);
    localparam int RW     = ADDR_W + 1;
    localparam int ENT_W  = 1 + lpct_pkg::KEY_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_W-1:0]     LAST_IDX = ADDR_W'(SLOTS - 1);

    logic [lpct_pkg::OPC_W-1:0]    op_reg;
    logic [lpct_pkg::KEY_W-1:0]    key_reg;
    logic [lpct_pkg::DIV_W-1:0]    key_sh_reg;
    logic [lpct_pkg::DIV_W-1:0]    key_sh_next;
    logic [ADDR_W-1:0]             rem_reg;
    logic [ADDR_W-1:0]             rem_next;
    logic [lpct_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic [ADDR_W-1:0]             idx_next;
    logic [SIZE_W-1:0]             probe_n_reg;
    logic [ENT_W-1:0]              rd_data_reg;
    logic [COUNT_BITS-1:0]         res_count_reg;
    logic [lpct_pkg::STATUS_W-1:0] res_status_reg;
    logic                          m_valid_reg;
    logic [lpct_pkg::OCOUNT_W-1:0] m_count_reg;
    logic [lpct_pkg::STATUS_W-1:0] m_status_reg;

    logic [ENT_W-1:0] mem [SLOTS];

    logic [SIZE_W-1:0]             size_eff;
    logic [RW-1:0]                 t;
    logic [SIZE_W-1:0]             idx_inc;
    logic                          rd_valid;
    logic [lpct_pkg::KEY_W-1:0]    rd_key;
    logic [COUNT_BITS-1:0]         rd_cnt;
    logic                          hit;
    logic                          stop;
    logic [COUNT_BITS-1:0]         cnt_inc;
    logic                          upd_en;
    logic [ENT_W-1:0]              upd_data;
    logic [COUNT_BITS-1:0]         fin_count;
    logic [lpct_pkg::STATUS_W-1:0] fin_status;
    logic [COUNT_BITS+lpct_pkg::OCOUNT_W-1:0] res_wide;

    // size 0 acts as 1, anything above the store acts as the store size
    always_comb
    begin
        if (table_size == '0)
            size_eff = SIZE_W'(1);
        else if (32'(table_size) > 32'(SLOTS))
            size_eff = SIZE_W'(SLOTS);
        else
            size_eff = SIZE_W'(table_size);
    end

    // restoring modulo, several key bits per cycle; remainder stays below size
    always_comb
    begin
        rem_next    = rem_reg;
        key_sh_next = key_sh_reg;
        t           = '0;
        for (int k = 0; k < lpct_pkg::DIV_DIGIT_BITS; k++)
        begin
            t           = {rem_next, key_sh_next[lpct_pkg::DIV_W-1]};
            key_sh_next = {key_sh_next[lpct_pkg::DIV_W-2:0], 1'b0};
            if (t >= RW'(size_eff))
                t = t - RW'(size_eff);
            rem_next = t[ADDR_W-1:0];
        end
    end

    // probe pointer wraps at the effective size
    always_comb
    begin
        idx_inc = SIZE_W'(idx_reg) + SIZE_W'(1);
        if (cmd.clear_step)
            idx_next = ADDR_W'(idx_reg + 1'b1);
        else if (idx_inc == size_eff)
            idx_next = '0;
        else
            idx_next = idx_inc[ADDR_W-1:0];
    end

    // slot check and update
    always_comb
    begin
        rd_valid   = rd_data_reg[ENT_W-1];
        rd_key     = rd_data_reg[ENT_W-2 -: lpct_pkg::KEY_W];
        rd_cnt     = rd_data_reg[COUNT_BITS-1:0];
        hit        = rd_valid && (rd_key == key_reg);
        stop       = !rd_valid || hit;
        if (!rd_valid)
            cnt_inc = COUNT_BITS'(1);
        else if (rd_cnt == CNT_MAX)
            cnt_inc = rd_cnt;
        else
            cnt_inc = rd_cnt + 1'b1;
        upd_en     = 1'b0;
        upd_data   = '0;
        fin_count  = '0;
        fin_status = lpct_pkg::STAT_OK;
        case (op_reg)
            lpct_pkg::OP_INSERT:
            begin
                if (stop)
                begin
                    upd_en    = 1'b1;
                    upd_data  = {1'b1, key_reg, cnt_inc};
                    fin_count = cnt_inc;
                end
                else
                begin
                    fin_status = lpct_pkg::STAT_FULL;
                end
            end
            lpct_pkg::OP_SEARCH:
            begin
                if (hit)
                    fin_count = rd_cnt;
            end
            lpct_pkg::OP_DELETE:
            begin
                if (hit)
                    upd_en = 1'b1;
                else
                    fin_status = lpct_pkg::STAT_MISSING;
            end
            default:
            begin
            end
        endcase
    end

    assign res_wide = (COUNT_BITS + lpct_pkg::OCOUNT_W)'(res_count_reg);

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[idx_reg] <= '0;
        else if (cmd.finish && upd_en)
            mem[idx_reg] <= upd_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (cmd.probe_init)
                idx_reg <= rem_reg;
            else if (cmd.probe_adv || cmd.clear_step)
                idx_reg <= idx_next;
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            key_reg    <= key;
            key_sh_reg <= lpct_pkg::DIV_W'(key);
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            key_sh_reg <= key_sh_next;
            rem_reg    <= rem_next;
        end
        if (cmd.probe_init)
            probe_n_reg <= '0;
        else if (cmd.probe_adv)
            probe_n_reg <= probe_n_reg + 1'b1;
        if (cmd.finish)
        begin
            res_count_reg  <= fin_count;
            res_status_reg <= fin_status;
        end
        else if (cmd.res_nop)
        begin
            res_count_reg  <= '0;
            res_status_reg <= lpct_pkg::STAT_OK;
        end
        if (cmd.out_load)
        begin
            m_count_reg  <= res_wide[lpct_pkg::OCOUNT_W-1:0];
            m_status_reg <= res_status_reg;
        end
    end

    assign stat.clear_last = (idx_reg == LAST_IDX);
    assign stat.op_nop     = (op_reg == lpct_pkg::OP_NOP);
    assign stat.div_last   = (div_cnt_reg == lpct_pkg::DIV_CNT_W'(lpct_pkg::DIV_STEPS - 1));
    assign stat.stop       = stop;
    assign stat.last_probe = (probe_n_reg == size_eff - SIZE_W'(1));
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign count    = m_count_reg;
    assign status   = m_status_reg;

endmodule

// File: rtl/lpct_ctrl.sv
// ----------------------------------------------------------------------------
// lpct_ctrl
// Controller: clears the slot store after reset, then sequences modulo,
// probe reads, slot check and result hand-off for each item.
// ----------------------------------------------------------------------------
module lpct_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lpct_pkg::lpct_stat_t stat,
    output lpct_pkg::lpct_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PINIT,
        S_RD,
        S_CMP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.op_nop)
                begin
                    cmd.res_nop = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_last)
                        state_next = S_PINIT;
                end
            end
            S_PINIT:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // stop on empty slot or key match, or after a full lap
                if (stat.stop || stat.last_probe)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
